[hw/rtl/mlm_pkg.sv]
package mlm_pkg;

   localparam int NUM_MUTEXES = 32;
   localparam int NUM_TASKS   = 64;

   localparam int CMD_W    = 2;
   localparam int MUTEX_W  = 5;
   localparam int TASK_W   = 6;
   localparam int STATUS_W = 3;
   // created count must hold NUM_MUTEXES itself
   localparam int CNT_W    = $clog2(NUM_MUTEXES + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE = 2'd0,
      CMD_LOCK   = 2'd1,
      CMD_UNLOCK = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACQUIRED = 3'd0,
      ST_QUEUED   = 3'd1,
      ST_INVALID  = 3'd2,
      ST_DEADLOCK = 3'd3,
      ST_FULL     = 3'd4,
      ST_RELEASED = 3'd5
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [MUTEX_W-1:0] mutex_id;
      logic [TASK_W-1:0]  task_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MUTEX_W-1:0]  new_mutex;
      logic                wake_valid;
      logic [TASK_W-1:0]   wake_task;
   } rsp_type;

   // per-mutex entry as read by the decision logic
   typedef struct packed {
      logic              locked;
      logic [TASK_W-1:0] holder;
      logic              nonempty;
      logic [TASK_W-1:0] tail;
   } entry_type;

   // table update produced by one transaction
   typedef struct packed {
      logic               count_inc;
      logic               entry_we;
      logic [MUTEX_W-1:0] mutex;
      logic               locked;
      logic [TASK_W-1:0]  holder;
      logic               nonempty;
      logic               head_we;
      logic [TASK_W-1:0]  head;
      logic               tail_we;
      logic [TASK_W-1:0]  tail;
   } upd_type;

endpackage

[hw/rtl/mlm_req_if.sv]
interface mlm_req_if import mlm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [MUTEX_W-1:0] mutex_id;
   logic [TASK_W-1:0]  task_id;

   modport source (output valid, output command, output mutex_id, output task_id,
                   input ready);
   modport sink   (input valid, input command, input mutex_id, input task_id,
                   output ready);
endinterface

[hw/rtl/mlm_rsp_if.sv]
interface mlm_rsp_if import mlm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [MUTEX_W-1:0]  new_mutex;
   logic                wake_valid;
   logic [TASK_W-1:0]   wake_task;

   modport source (output valid, output status, output new_mutex, output wake_valid,
                   output wake_task, input ready);
   modport sink   (input valid, input status, input new_mutex, input wake_valid,
                   input wake_task, output ready);
endinterface

[hw/rtl/mlm_ram.sv]
module mlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mlm_state.sv]
module mlm_state import mlm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [MUTEX_W-1:0] look_mutex,
   output logic [TASK_W-1:0]  look_head,
   input  logic [MUTEX_W-1:0] cur_mutex,
   output entry_type          cur_entry,
   output logic [CNT_W-1:0]   created_count,
   input  logic               commit,
   input  upd_type            upd
);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              locked_ff   [NUM_MUTEXES];
   logic [TASK_W-1:0] holder_ff   [NUM_MUTEXES];
   logic              nonempty_ff [NUM_MUTEXES];
   logic [TASK_W-1:0] head_ff     [NUM_MUTEXES];
   logic [TASK_W-1:0] tail_ff     [NUM_MUTEXES];

   assign count_in = (commit && upd.count_inc) ? count_ff + CNT_W'(1) : count_ff;

   // flags and holder: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < NUM_MUTEXES; i++) begin
            locked_ff[i]   <= 1'b0;
            holder_ff[i]   <= '0;
            nonempty_ff[i] <= 1'b0;
         end
      end else begin
         count_ff <= count_in;
         if (commit && upd.entry_we) begin
            locked_ff[upd.mutex]   <= upd.locked;
            holder_ff[upd.mutex]   <= upd.holder;
            nonempty_ff[upd.mutex] <= upd.nonempty;
         end
      end
   end

   // queue pointers: only used while the queue is nonempty
   always_ff @(posedge clock) begin
      if (commit && upd.head_we) begin
         head_ff[upd.mutex] <= upd.head;
      end
      if (commit && upd.tail_we) begin
         tail_ff[upd.mutex] <= upd.tail;
      end
   end

   assign look_head          = head_ff[look_mutex];
   assign cur_entry.locked   = locked_ff[cur_mutex];
   assign cur_entry.holder   = holder_ff[cur_mutex];
   assign cur_entry.nonempty = nonempty_ff[cur_mutex];
   assign cur_entry.tail     = tail_ff[cur_mutex];
   assign created_count      = count_ff;

endmodule

[hw/rtl/mutex_lock_manager.sv]
// Path: an accepted transaction is registered in the request stage, then its result
//   in the result register (two-register path); a stalled receiver holds it in s1.
// Throughput: one transaction per cycle unless the receiver stalls; every command
//   touches one mutex entry and at most one wait-queue link in the link RAM.
// Reset: synchronous, active high. Clears the created count, locked, holder and
//   queue-nonempty flags. Queue head/tail pointers and links are not cleared.
module mutex_lock_manager import mlm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   mlm_req_if.sink      req_port,
   mlm_rsp_if.source    rsp_port
);

   // ---------------------------------------------------------------------
   // Handshake / pipeline control
   // ---------------------------------------------------------------------
   logic              accept;
   logic              advance;
   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_req_ff;
   logic [TASK_W-1:0] s1_head_ff;     // queue head of s1 mutex, forwarded
   logic              link_hit_ff;    // link read collided with a write
   logic [TASK_W-1:0] link_byp_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !s1_valid_ff || advance;
   assign accept         = req_port.valid && req_port.ready;

   // ---------------------------------------------------------------------
   // Mutex table and link RAM
   // ---------------------------------------------------------------------
   logic [TASK_W-1:0] look_head_raw;
   logic [TASK_W-1:0] look_head;
   entry_type         ent;
   logic [CNT_W-1:0]  created_count;
   upd_type           upd;
   logic              link_we;
   logic [TASK_W-1:0] link_waddr;
   logic [TASK_W-1:0] link_wdata;
   logic [TASK_W-1:0] link_rdata;
   logic [TASK_W-1:0] link;

   mlm_state u_state (
      .clock         (clock),
      .reset         (reset),
      .look_mutex    (req_port.mutex_id),
      .look_head     (look_head_raw),
      .cur_mutex     (s1_req_ff.mutex_id),
      .cur_entry     (ent),
      .created_count (created_count),
      .commit        (advance),
      .upd           (upd)
   );

   // The head for the incoming transaction is looked up at accept time so the
   // link RAM read of its successor lands together with it in the request
   // stage. The transaction leaving s1 in the same cycle may rewrite that head.
   assign look_head = (advance && upd.head_we && (upd.mutex == req_port.mutex_id)) ?
                      upd.head : look_head_raw;

   mlm_ram #(
      .WIDTH (TASK_W),
      .DEPTH (NUM_TASKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (advance && link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (accept),
      .rd_addr (look_head),
      .rd_data (link_rdata)
   );

   // read-during-write on the same link: take the new value
   assign link = link_hit_ff ? link_byp_ff : link_rdata;

   // ---------------------------------------------------------------------
   // Request stage
   // ---------------------------------------------------------------------
   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff.command  <= req_port.command;
         s1_req_ff.mutex_id <= req_port.mutex_id;
         s1_req_ff.task_id  <= req_port.task_id;
         s1_head_ff         <= look_head;
         link_hit_ff        <= advance && link_we && (link_waddr == look_head);
         link_byp_ff        <= link_wdata;
      end
   end

   // ---------------------------------------------------------------------
   // Command decision
   // ---------------------------------------------------------------------
   logic mutex_ok;
   logic task_ok;

   assign mutex_ok = (CNT_W'(s1_req_ff.mutex_id) < CNT_W'(NUM_MUTEXES)) &&
                     (CNT_W'(s1_req_ff.mutex_id) < created_count);
   assign task_ok  = ({1'b0, s1_req_ff.task_id} < (TASK_W + 1)'(NUM_TASKS));

   always_comb begin
      rsp_in           = '0;
      rsp_in.status    = ST_INVALID;
      upd              = '0;
      upd.mutex        = s1_req_ff.mutex_id;
      upd.locked       = ent.locked;
      upd.holder       = ent.holder;
      upd.nonempty     = ent.nonempty;
      link_we          = 1'b0;
      link_waddr       = ent.tail;
      link_wdata       = s1_req_ff.task_id;

      case (s1_req_ff.command)
         CMD_CREATE: begin
            if (created_count < CNT_W'(NUM_MUTEXES)) begin
               rsp_in.status    = ST_ACQUIRED;
               rsp_in.new_mutex = created_count[MUTEX_W-1:0];
               upd.count_inc    = 1'b1;
               upd.entry_we     = 1'b1;
               upd.mutex        = created_count[MUTEX_W-1:0];
               upd.locked       = 1'b0;
               upd.holder       = '0;
               upd.nonempty     = 1'b0;
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         CMD_LOCK: begin
            if (mutex_ok && task_ok) begin
               if (!ent.locked) begin
                  rsp_in.status = ST_ACQUIRED;
                  upd.entry_we  = 1'b1;
                  upd.locked    = 1'b1;
                  upd.holder    = s1_req_ff.task_id;
               end else if (ent.holder == s1_req_ff.task_id) begin
                  rsp_in.status = ST_DEADLOCK;
               end else begin
                  // append to the wait queue
                  rsp_in.status = ST_QUEUED;
                  upd.entry_we  = 1'b1;
                  upd.nonempty  = 1'b1;
                  if (!ent.nonempty) begin
                     upd.head_we = 1'b1;
                     upd.head    = s1_req_ff.task_id;
                  end else begin
                     link_we = 1'b1;
                  end
                  upd.tail_we = 1'b1;
                  upd.tail    = s1_req_ff.task_id;
               end
            end
         end
         CMD_UNLOCK: begin
            if (mutex_ok) begin
               rsp_in.status = ST_RELEASED;
               upd.entry_we  = 1'b1;
               if (!ent.nonempty) begin
                  upd.locked = 1'b0;
                  upd.holder = '0;
               end else begin
                  // hand over to the queue head
                  upd.locked        = 1'b1;
                  upd.holder        = s1_head_ff;
                  rsp_in.wake_valid = 1'b1;
                  rsp_in.wake_task  = s1_head_ff;
                  if (s1_head_ff == ent.tail) begin
                     upd.nonempty = 1'b0;
                  end else begin
                     upd.head_we = 1'b1;
                     upd.head    = link;
                  end
               end
            end
         end
         default: begin
            rsp_in.status = ST_INVALID;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   assign rsp_valid_in = advance ? 1'b1 : (rsp_port.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.status     = rsp_ff.status;
   assign rsp_port.new_mutex  = rsp_ff.new_mutex;
   assign rsp_port.wake_valid = rsp_ff.wake_valid;
   assign rsp_port.wake_task  = rsp_ff.wake_task;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      created_count <= CNT_W'(NUM_MUTEXES))
      else $error("created count beyond table size");

   a_wake_on_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.wake_valid |-> rsp_ff.status == ST_RELEASED)
      else $error("wake reported without release");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("request stage overwritten while stalled");

   a_create_count: assert property (@(posedge clock) disable iff (reset)
      advance && upd.count_inc |=> created_count == $past(created_count) + CNT_W'(1))
      else $error("create did not advance the count");

endmodule

[dv/mlm_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, predicts each response from a private copy of the
// lock table and compares it with what the block returns, oldest first.
module mlm_checker import mlm_pkg::*; (
   input  logic clock,
   input  logic reset,
   mlm_req_if   req_mon,
   mlm_rsp_if   rsp_mon,
   output int   errors,
   output int   pending
);

   // private copy of the lock table
   logic [CNT_W-1:0]  made_count;
   logic              busy        [NUM_MUTEXES];
   logic [TASK_W-1:0] owner       [NUM_MUTEXES];
   logic              has_waiters [NUM_MUTEXES];
   logic [TASK_W-1:0] wait_head   [NUM_MUTEXES];
   logic [TASK_W-1:0] wait_tail   [NUM_MUTEXES];
   logic [TASK_W-1:0] next_in_line[NUM_TASKS];

   rsp_type expected_q[$];
   rsp_type exp_rsp;
   rsp_type got_rsp;
   req_type seen_req;
   int      fail_count = 0;
   int      queued = 0;

   assign errors  = fail_count;
   assign pending = queued;

   initial begin
      for (int i = 0; i < NUM_MUTEXES; i++) begin
         wait_head[i] = '0;
         wait_tail[i] = '0;
      end
      for (int i = 0; i < NUM_TASKS; i++) next_in_line[i] = '0;
   end

   // applies one command to the table copy, returns the response it earns
   function automatic rsp_type lock_table_step(input req_type r);
      rsp_type           o;
      logic [TASK_W-1:0] h;
      o = '0;
      o.status = ST_INVALID;
      case (r.command)
         CMD_CREATE: begin
            if (made_count < NUM_MUTEXES) begin
               o.new_mutex = made_count[MUTEX_W-1:0];
               busy[o.new_mutex]        = 1'b0;
               owner[o.new_mutex]       = '0;
               has_waiters[o.new_mutex] = 1'b0;
               made_count = made_count + 1'b1;
               o.status = ST_ACQUIRED;
            end else begin
               o.status = ST_FULL;
            end
         end
         CMD_LOCK: begin
            if (r.mutex_id < made_count && int'(r.task_id) < NUM_TASKS) begin
               if (!busy[r.mutex_id]) begin
                  busy[r.mutex_id]  = 1'b1;
                  owner[r.mutex_id] = r.task_id;
                  o.status = ST_ACQUIRED;
               end else if (owner[r.mutex_id] == r.task_id) begin
                  o.status = ST_DEADLOCK;
               end else begin
                  if (!has_waiters[r.mutex_id]) begin
                     wait_head[r.mutex_id]   = r.task_id;
                     has_waiters[r.mutex_id] = 1'b1;
                  end else begin
                     next_in_line[wait_tail[r.mutex_id]] = r.task_id;
                  end
                  wait_tail[r.mutex_id] = r.task_id;
                  o.status = ST_QUEUED;
               end
            end
         end
         CMD_UNLOCK: begin
            if (r.mutex_id < made_count) begin
               if (!has_waiters[r.mutex_id]) begin
                  busy[r.mutex_id]  = 1'b0;
                  owner[r.mutex_id] = '0;
               end else begin
                  h = wait_head[r.mutex_id];
                  busy[r.mutex_id]  = 1'b1;
                  owner[r.mutex_id] = h;
                  if (h == wait_tail[r.mutex_id])
                     has_waiters[r.mutex_id] = 1'b0;
                  else
                     wait_head[r.mutex_id] = next_in_line[h];
                  o.wake_valid = 1'b1;
                  o.wake_task  = h;
               end
               o.status = ST_RELEASED;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         made_count = '0;
         for (int i = 0; i < NUM_MUTEXES; i++) begin
            busy[i]        = 1'b0;
            owner[i]       = '0;
            has_waiters[i] = 1'b0;
         end
         expected_q.delete();
         queued = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            seen_req.command  = req_mon.command;
            seen_req.mutex_id = req_mon.mutex_id;
            seen_req.task_id  = req_mon.task_id;
            expected_q.push_back(lock_table_step(seen_req));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_rsp.status     = rsp_mon.status;
            got_rsp.new_mutex  = rsp_mon.new_mutex;
            got_rsp.wake_valid = rsp_mon.wake_valid;
            got_rsp.wake_task  = rsp_mon.wake_task;
            if (expected_q.size() == 0) begin
               $error("response with no outstanding request: status %0d", got_rsp.status);
               fail_count++;
            end else begin
               exp_rsp = expected_q.pop_front();
               if (got_rsp.status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d", exp_rsp.status, got_rsp.status);
                  fail_count++;
               end
               if (got_rsp.new_mutex !== exp_rsp.new_mutex) begin
                  $error("new_mutex: expected %0d, got %0d",
                         exp_rsp.new_mutex, got_rsp.new_mutex);
                  fail_count++;
               end
               if (got_rsp.wake_valid !== exp_rsp.wake_valid) begin
                  $error("wake_valid: expected %0d, got %0d",
                         exp_rsp.wake_valid, got_rsp.wake_valid);
                  fail_count++;
               end
               if (got_rsp.wake_task !== exp_rsp.wake_task) begin
                  $error("wake_task: expected %0d, got %0d",
                         exp_rsp.wake_task, got_rsp.wake_task);
                  fail_count++;
               end
            end
         end
         queued = expected_q.size();
      end
   end

endmodule

[dv/tb_mutex_lock_manager.sv]
`timescale 1ns / 1ps

// Lock manager testbench. The top only makes stimulus and gives the verdict;
// prediction and comparison live in mlm_checker.
module tb_mutex_lock_manager;
   import mlm_pkg::*;

   // command code the block does not know; must answer invalid
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int ITEMS_PER_PHASE = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct = 0;   // chance in 100 that the sender skips a cycle
   int recv_idle_pct = 0;   // chance in 100 that the receiver stalls a cycle
   int made_cnt      = 0;   // mutexes created so far, as seen by the sender
   int errors;
   int pending_rsp;

   mlm_req_if req_bus();
   mlm_rsp_if rsp_bus();

   mutex_lock_manager uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   mlm_checker lock_check (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_bus),
      .rsp_mon (rsp_bus),
      .errors  (errors),
      .pending (pending_rsp)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver backpressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // hard stop in case the block hangs or drops a response
   initial begin
      #2_000_000;
      $display("tb_mutex_lock_manager: errors");
      $finish;
   end

   // Drives one transaction starting at a falling edge and returns at the
   // falling edge after it was accepted. Valid is only dropped when the
   // sender decides to idle, so back-to-back transactions keep it high.
   task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [MUTEX_W-1:0] m,
                           input logic [TASK_W-1:0] t);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= c;
      req_bus.mutex_id <= m;
      req_bus.task_id  <= t;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (c == CMD_CREATE && made_cnt < NUM_MUTEXES) made_cnt++;
      @(negedge clock);
   endtask

   // sender holds off until every outstanding response is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_rsp != 0);
   endtask

   // Random transaction. Half target a handful of hot mutexes and half use a small
   // task pool so that queues build up, waiters repeat and deadlocks occur; the
   // rest spread over created or all mutexes (incl. ones never created) and tasks.
   task automatic send_random();
      int                 roll;
      int                 span;
      logic [CMD_W-1:0]   c;
      logic [MUTEX_W-1:0] m;
      logic [TASK_W-1:0]  t;
      roll = $urandom_range(99);
      if (roll < 6)       c = CMD_CREATE;
      else if (roll < 58) c = CMD_LOCK;
      else if (roll < 96) c = CMD_UNLOCK;
      else                c = CMD_UNUSED;
      roll = $urandom_range(99);
      span = (made_cnt < 4) ? made_cnt : 4;
      if (made_cnt == 0 || roll >= 85) m = MUTEX_W'($urandom_range(NUM_MUTEXES - 1));
      else if (roll < 50)              m = MUTEX_W'($urandom_range(span - 1));
      else                             m = MUTEX_W'($urandom_range(made_cnt - 1));
      roll = $urandom_range(99);
      if (roll < 50)      t = TASK_W'($urandom_range(7));
      else if (roll < 60) t = TASK_W'($urandom_range(NUM_TASKS - 1, NUM_TASKS - 8));
      else                t = TASK_W'($urandom_range(NUM_TASKS - 1));
      send_cmd(c, m, t);
   endtask

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_CREATE;
      req_bus.mutex_id = '0;
      req_bus.task_id  = '0;
      rsp_bus.ready    = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part runs under the first idling profile
      send_idle_pct = 35;
      recv_idle_pct = 79;

      // nothing created yet: every lock/unlock is invalid, as is the unused code
      send_cmd(CMD_LOCK,   5'd0,  6'd5);
      send_cmd(CMD_UNLOCK, 5'd0,  6'd0);
      send_cmd(CMD_UNUSED, 5'd0,  6'd0);
      send_cmd(CMD_CREATE, 5'd0,  6'd0);
      send_cmd(CMD_CREATE, 5'd31, 6'd63);
      // mutex above the created range
      send_cmd(CMD_LOCK,   5'd31, 6'd63);
      send_cmd(CMD_UNLOCK, 5'd2,  6'd0);
      // grant, then holder locks again -> deadlock
      send_cmd(CMD_LOCK,   5'd0,  6'd0);
      send_cmd(CMD_LOCK,   5'd0,  6'd0);
      // two waiters, then the first waits a second time
      send_cmd(CMD_LOCK,   5'd0,  6'd63);
      send_cmd(CMD_LOCK,   5'd0,  6'd1);
      send_cmd(CMD_LOCK,   5'd0,  6'd63);
      send_cmd(CMD_LOCK,   5'd1,  6'd63);
      // hand-offs to the queue head, then plain release
      send_cmd(CMD_UNLOCK, 5'd0,  6'd0);
      send_cmd(CMD_UNLOCK, 5'd0,  6'd0);
      send_cmd(CMD_UNLOCK, 5'd0,  6'd0);
      send_cmd(CMD_UNLOCK, 5'd0,  6'd0);
      // unlock does not check the caller
      send_cmd(CMD_UNLOCK, 5'd1,  6'd42);
      send_cmd(CMD_LOCK,   5'd1,  6'd42);
      send_cmd(CMD_LOCK,   5'd1,  6'd21);
      send_cmd(CMD_UNLOCK, 5'd1,  6'd42);
      send_cmd(CMD_UNLOCK, 5'd1,  6'd21);
      send_cmd(CMD_UNUSED, 5'd31, 6'd63);
      drain();

      // random part: slow receiver, then slow sender, then full rate;
      // the table fills up along the way, so later creates hit table full
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random();
         drain();
      end

      // a few more cycles so a stray extra response would still be caught
      repeat (8) @(negedge clock);
      if (errors == 0)
         $display("tb_mutex_lock_manager: clean");
      else
         $display("tb_mutex_lock_manager: errors");
      $finish;
   end

endmodule

[files.f]
hw/rtl/mlm_pkg.sv
hw/rtl/mlm_req_if.sv
hw/rtl/mlm_rsp_if.sv
hw/rtl/mlm_ram.sv
hw/rtl/mlm_state.sv
hw/rtl/mutex_lock_manager.sv
dv/mlm_checker.sv
dv/tb_mutex_lock_manager.sv
